// ===== rtl/occ_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the orbit camera controller.
`timescale 1ns / 1ps

package occ_pkg;

  // Event codes carried on the input tuser lane.
  typedef enum logic [2:0] {
    CMD_FORWARD = 3'd0,
    CMD_PRESS   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_SCROLL  = 3'd3,
    CMD_CURSOR  = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_t;

  // Configuration register indexes.
  localparam logic CFG_MAX_CURSOR_STEP = 1'b0;
  localparam logic CFG_RECENTER_STEP   = 1'b1;

  // Q16.16 constants.
  localparam logic signed [31:0] ONE_Q16       = 32'sd65536;
  localparam logic signed [31:0] DIST_RESET    = 32'sd3276800;
  localparam logic signed [33:0] FULL_TURN_Q16 = 34'sd23592960;
  localparam logic        [30:0] MAX_STEP_RST  = 31'd6553600;
  localparam logic        [30:0] RECENTER_RST  = 31'd131072;

  // Angle reduction: offset that makes any 33-bit angle positive, a multiple of a turn.
  localparam logic [33:0] TURN_OFFSET  = 34'd4317511680;
  localparam logic [33:0] TURN_Q16     = 34'd23592960;
  localparam logic [33:0] HALF_TURN    = 34'd11796480;
  localparam int          RED_STEPS    = 9;

  // CORDIC constants: angles in degrees scaled by 2^24, vectors in Q30.
  localparam logic signed [33:0] QUARTER_Z   = 34'sd1509949440;
  localparam logic signed [33:0] HALF_Z      = 34'sd3019898880;
  localparam logic signed [31:0] INV_GAIN    = 32'sd652032874;
  localparam int                 ATAN_LEN    = 30;

  // Reciprocal of ten for a 32-bit unsigned quotient taken at bit 35.
  localparam logic signed [33:0] RECIP_TEN   = 34'sh0CCCCCCCD;
  localparam int                 RECIP_SHIFT = 35;

  // Sine/cosine unit sequencer.
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_RED,
    SC_FOLD,
    SC_ROT
  } sc_state_t;

  // Top-level sequencer.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_DIVEND,
    ST_SC_P,
    ST_WAIT_P,
    ST_SC_T,
    ST_WAIT_T,
    ST_M_HOR,
    ST_M_VER,
    ST_M_X,
    ST_M_Z,
    ST_M_END,
    ST_OUT
  } state_t;

  // Handshake between the sequencer and the sine/cosine unit.
  typedef struct packed {
    logic done;
    logic busy;
  } sc_status_t;

  // Arctangent of 2^-i in degrees scaled by 2^24.
  function automatic logic [29:0] atan_deg(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      5'd24: v = 30'd57;
      5'd25: v = 30'd29;
      5'd26: v = 30'd14;
      5'd27: v = 30'd7;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/occ_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module occ_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] prod
);

  logic signed [67:0] prod_r;

  // One product per cycle, available on the next cycle.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/occ_sincos.sv =====
// Iterative sine/cosine unit: angle reduction, quadrant fold and CORDIC rotation.
`timescale 1ns / 1ps

module occ_sincos #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [32:0]       angle,
  output occ_pkg::sc_status_t      status,
  output logic signed [31:0]       sin_o,
  output logic signed [31:0]       cos_o
);

  localparam int NSTEP = (CORDIC_STEPS < occ_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                            : occ_pkg::ATAN_LEN;
  localparam int CW = $clog2(NSTEP);

  occ_pkg::sc_state_t state_r, state_nxt;
  logic [33:0]        u_r;
  logic [3:0]         red_cnt_r;
  logic [CW-1:0]      rot_cnt_r;
  logic signed [33:0] z_r;
  logic signed [31:0] x_r, y_r;
  logic               neg_r;
  logic               done_r;
  logic signed [31:0] sin_r, cos_r;

  logic [33:0]        red_sub;
  logic signed [33:0] r_c, z_c;
  logic signed [31:0] xs, ys, x_nxt, y_nxt;
  logic signed [33:0] z_nxt, atan_v;
  logic               rot_last;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      occ_pkg::SC_IDLE: if (start) state_nxt = occ_pkg::SC_RED;
      occ_pkg::SC_RED:  if (red_cnt_r == 4'd0) state_nxt = occ_pkg::SC_FOLD;
      occ_pkg::SC_FOLD: state_nxt = occ_pkg::SC_ROT;
      occ_pkg::SC_ROT:  if (rot_last) state_nxt = occ_pkg::SC_IDLE;
      default:          state_nxt = occ_pkg::SC_IDLE;
    endcase
  end

  // Datapath: one restoring subtract or one rotation per cycle.
  always_comb begin
    red_sub  = occ_pkg::TURN_Q16 << red_cnt_r;
    r_c      = (u_r >= occ_pkg::HALF_TURN) ? $signed(u_r) - $signed(occ_pkg::TURN_Q16)
                                           : $signed(u_r);
    z_c      = r_c <<< 8;
    xs       = x_r >>> rot_cnt_r;
    ys       = y_r >>> rot_cnt_r;
    atan_v   = $signed({4'd0, occ_pkg::atan_deg(5'(rot_cnt_r))});
    rot_last = (rot_cnt_r == CW'(NSTEP - 1));
    if (!z_r[33]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= occ_pkg::SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == occ_pkg::SC_ROT) && rot_last;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      occ_pkg::SC_IDLE: begin
        u_r       <= $unsigned({angle[32], angle}) + occ_pkg::TURN_OFFSET;
        red_cnt_r <= 4'(occ_pkg::RED_STEPS - 1);
      end
      occ_pkg::SC_RED: begin
        if (u_r >= red_sub) u_r <= u_r - red_sub;
        red_cnt_r <= red_cnt_r - 4'd1;
      end
      occ_pkg::SC_FOLD: begin
        // Fold into the right half plane and remember to negate.
        if (z_c > occ_pkg::QUARTER_Z) begin
          z_r   <= z_c - occ_pkg::HALF_Z;
          neg_r <= 1'b1;
        end else if (z_c < -occ_pkg::QUARTER_Z) begin
          z_r   <= z_c + occ_pkg::HALF_Z;
          neg_r <= 1'b1;
        end else begin
          z_r   <= z_c;
          neg_r <= 1'b0;
        end
        x_r       <= occ_pkg::INV_GAIN;
        y_r       <= 32'sd0;
        rot_cnt_r <= '0;
      end
      occ_pkg::SC_ROT: begin
        x_r       <= x_nxt;
        y_r       <= y_nxt;
        z_r       <= z_nxt;
        rot_cnt_r <= rot_cnt_r + CW'(1);
        if (rot_last) begin
          sin_r <= neg_r ? -y_nxt : y_nxt;
          cos_r <= neg_r ? -x_nxt : x_nxt;
        end
      end
      default: ;
    endcase
  end

  assign status.done = done_r;
  assign status.busy = (state_r != occ_pkg::SC_IDLE);
  assign sin_o       = sin_r;
  assign cos_o       = cos_r;

endmodule

// ===== rtl/orbit_camera_controller.sv =====
// Orbit camera controller: event decoder, sequencer and camera position datapath.
// Non-tick events are handled in the idle state; a cursor event while dragging also
// passes through ST_DIVX, ST_DIVY and ST_DIVEND. A tick makes two passes through the
// shared sine/cosine unit and four products on the shared multiplier.
// One item at a time; the result register lets the next item start before it is taken.
// Synchronous active-low reset restores the configuration registers and camera state to their defaults.
`timescale 1ns / 1ps

module orbit_camera_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: scroll_amount, cursor_x, cursor_y, player_x, player_y, player_z,
  // player_heading (32 bits each, from bit 0 up).
  input  logic [223:0] in_tdata,
  // tuser: cmd.
  input  logic [2:0]   in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: cam_x, cam_y, cam_z, cam_pitch, cam_yaw (32 bits each, from bit 0 up).
  output logic [159:0] out_tdata,
  // Configuration channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);

  occ_pkg::state_t state_r, state_nxt;

  logic [30:0]        max_step_r, recenter_step_r;
  logic signed [31:0] pitch_r, orbit_r, dist_r, last_x_r, last_y_r;
  logic               dragging_r, recentering_r;
  logic signed [31:0] px_r, py_r, pz_r, heading_r;
  logic [31:0]        mx_r, my_r;
  logic               nx_r, ny_r;
  logic signed [31:0] sp_r, cp_r, st_r, ct_r, ver_r, offx_r, offz_r;
  logic signed [32:0] hor_r;
  logic               out_valid_r;
  logic [159:0]       out_data_r;

  logic signed [31:0] f_scroll, f_cx, f_cy, f_px, f_py, f_pz, f_head;
  logic               accept, out_free;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [67:0] prod_rnd;
  logic signed [33:0] quot;
  logic               sc_start;
  logic signed [32:0] sc_angle;
  occ_pkg::sc_status_t sc_st;
  logic signed [31:0] sc_sin, sc_cos;
  logic signed [32:0] dx, dy, lim;
  logic signed [31:0] orbit_step, orbit_snap;
  logic signed [32:0] theta;
  logic signed [31:0] cam_x, cam_y, cam_z, cam_yaw;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign f_scroll = in_tdata[31:0];
  assign f_cx     = in_tdata[63:32];
  assign f_cy     = in_tdata[95:64];
  assign f_px     = in_tdata[127:96];
  assign f_py     = in_tdata[159:128];
  assign f_pz     = in_tdata[191:160];
  assign f_head   = in_tdata[223:192];

  assign in_tready = (state_r == occ_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  occ_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  occ_sincos #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_sincos (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sc_start),
    .angle  (sc_angle),
    .status (sc_st),
    .sin_o  (sc_sin),
    .cos_o  (sc_cos)
  );

  // Cursor deltas, clamped to zero when oversized.
  always_comb begin
    lim = $signed({2'b00, max_step_r});
    dx  = {f_cx[31], f_cx} - {last_x_r[31], last_x_r};
    dy  = {f_cy[31], f_cy} - {last_y_r[31], last_y_r};
    if (dx > lim || dx < -lim) dx = 33'sd0;
    if (dy > lim || dy < -lim) dy = 33'sd0;
  end

  // Re-centering step toward zero with snap below one degree.
  always_comb begin
    if (orbit_r > 32'sd0) begin
      orbit_step = sat32({{2{orbit_r[31]}}, orbit_r} - $signed({3'b000, recenter_step_r}));
    end else begin
      orbit_step = sat32({{2{orbit_r[31]}}, orbit_r} + $signed({3'b000, recenter_step_r}));
    end
    orbit_snap = (orbit_step < occ_pkg::ONE_Q16 && orbit_step > -occ_pkg::ONE_Q16)
                 ? 32'sd0 : orbit_step;
  end

  // Quotient by ten and rounded Q30 product taps.
  assign quot     = $signed({5'd0, prod[63:occ_pkg::RECIP_SHIFT]});
  assign prod_rnd = prod + (68'sd1 <<< 29);
  assign theta    = {heading_r[31], heading_r} + {orbit_r[31], orbit_r};

  // Result fields.
  assign cam_x   = px_r + offx_r;
  assign cam_y   = py_r + ver_r;
  assign cam_z   = pz_r + offz_r;
  assign cam_yaw = occ_pkg::FULL_TURN_Q16[31:0] - theta[31:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      occ_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == occ_pkg::CMD_CURSOR && dragging_r) state_nxt = occ_pkg::ST_DIVX;
          else if (in_tuser == occ_pkg::CMD_TICK)            state_nxt = occ_pkg::ST_SC_P;
        end
      end
      occ_pkg::ST_DIVX:   state_nxt = occ_pkg::ST_DIVY;
      occ_pkg::ST_DIVY:   state_nxt = occ_pkg::ST_DIVEND;
      occ_pkg::ST_DIVEND: state_nxt = occ_pkg::ST_IDLE;
      occ_pkg::ST_SC_P:   state_nxt = occ_pkg::ST_WAIT_P;
      occ_pkg::ST_WAIT_P: if (sc_st.done) state_nxt = occ_pkg::ST_SC_T;
      occ_pkg::ST_SC_T:   state_nxt = occ_pkg::ST_WAIT_T;
      occ_pkg::ST_WAIT_T: if (sc_st.done) state_nxt = occ_pkg::ST_M_HOR;
      occ_pkg::ST_M_HOR:  state_nxt = occ_pkg::ST_M_VER;
      occ_pkg::ST_M_VER:  state_nxt = occ_pkg::ST_M_X;
      occ_pkg::ST_M_X:    state_nxt = occ_pkg::ST_M_Z;
      occ_pkg::ST_M_Z:    state_nxt = occ_pkg::ST_M_END;
      occ_pkg::ST_M_END:  state_nxt = occ_pkg::ST_OUT;
      occ_pkg::ST_OUT:    if (out_free) state_nxt = occ_pkg::ST_IDLE;
      default:            state_nxt = occ_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operands and sine/cosine unit control per state.
  always_comb begin
    mul_a    = 34'sd0;
    mul_b    = 34'sd0;
    sc_start = 1'b0;
    sc_angle = theta;
    unique case (state_r)
      occ_pkg::ST_DIVX: begin
        mul_a = $signed({2'b00, mx_r + 32'd5});
        mul_b = occ_pkg::RECIP_TEN;
      end
      occ_pkg::ST_DIVY: begin
        mul_a = $signed({2'b00, my_r + 32'd5});
        mul_b = occ_pkg::RECIP_TEN;
      end
      occ_pkg::ST_SC_P: begin
        sc_start = 1'b1;
        sc_angle = {pitch_r[31], pitch_r};
      end
      occ_pkg::ST_SC_T: sc_start = 1'b1;
      occ_pkg::ST_M_HOR: begin
        mul_a = {{2{dist_r[31]}}, dist_r};
        mul_b = {{2{cp_r[31]}}, cp_r};
      end
      occ_pkg::ST_M_VER: begin
        mul_a = {{2{dist_r[31]}}, dist_r};
        mul_b = {{2{sp_r[31]}}, sp_r};
      end
      occ_pkg::ST_M_X: begin
        mul_a = {hor_r[32], hor_r};
        mul_b = {{2{st_r[31]}}, st_r};
      end
      occ_pkg::ST_M_Z: begin
        mul_a = {hor_r[32], hor_r};
        mul_b = {{2{ct_r[31]}}, ct_r};
      end
      default: ;
    endcase
  end

  // Control state and camera state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= occ_pkg::ST_IDLE;
      max_step_r      <= occ_pkg::MAX_STEP_RST;
      recenter_step_r <= occ_pkg::RECENTER_RST;
      pitch_r         <= 32'sd0;
      orbit_r         <= 32'sd0;
      dist_r          <= occ_pkg::DIST_RESET;
      dragging_r      <= 1'b0;
      recentering_r   <= 1'b0;
      last_x_r        <= 32'sd0;
      last_y_r        <= 32'sd0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == occ_pkg::CFG_MAX_CURSOR_STEP) max_step_r <= cfg_data;
        else                                           recenter_step_r <= cfg_data;
      end
      if (state_r == occ_pkg::ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready)        out_valid_r <= 1'b0;
      case (state_r)
        occ_pkg::ST_IDLE: begin
          if (accept) begin
            case (in_tuser)
              occ_pkg::CMD_FORWARD: if (orbit_r != 32'sd0) recentering_r <= 1'b1;
              occ_pkg::CMD_PRESS:   dragging_r <= 1'b1;
              occ_pkg::CMD_RELEASE: dragging_r <= 1'b0;
              occ_pkg::CMD_SCROLL:
                dist_r <= sat32({{2{dist_r[31]}}, dist_r} - {{2{f_scroll[31]}}, f_scroll});
              occ_pkg::CMD_CURSOR: begin
                if (dragging_r) begin
                  last_x_r <= f_cx;
                  last_y_r <= f_cy;
                end
              end
              occ_pkg::CMD_TICK: begin
                if (recentering_r) begin
                  orbit_r <= orbit_snap;
                  if (orbit_snap == 32'sd0) recentering_r <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        occ_pkg::ST_DIVY:
          orbit_r <= sat32({{2{orbit_r[31]}}, orbit_r} - (nx_r ? -quot : quot));
        occ_pkg::ST_DIVEND:
          pitch_r <= sat32({{2{pitch_r[31]}}, pitch_r} + (ny_r ? -quot : quot));
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r      <= f_px;
      py_r      <= f_py;
      pz_r      <= f_pz;
      heading_r <= f_head;
      nx_r      <= dx[32];
      ny_r      <= dy[32];
      mx_r      <= dx[32] ? 32'(-dx) : dx[31:0];
      my_r      <= dy[32] ? 32'(-dy) : dy[31:0];
    end
    if (state_r == occ_pkg::ST_WAIT_P && sc_st.done) begin
      sp_r <= sc_sin;
      cp_r <= sc_cos;
    end
    if (state_r == occ_pkg::ST_WAIT_T && sc_st.done) begin
      st_r <= sc_sin;
      ct_r <= sc_cos;
    end
    if (state_r == occ_pkg::ST_M_VER) hor_r  <= prod_rnd[62:30];
    if (state_r == occ_pkg::ST_M_X)   ver_r  <= prod_rnd[61:30];
    if (state_r == occ_pkg::ST_M_Z)   offx_r <= prod_rnd[61:30];
    if (state_r == occ_pkg::ST_M_END) offz_r <= prod_rnd[61:30];
    if (state_r == occ_pkg::ST_OUT && out_free) begin
      out_data_r <= {cam_yaw, pitch_r, cam_z, cam_y, cam_x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The sine/cosine unit reports completion only while the sequencer waits for it.
  a_sc_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sc_st.done |-> (state_r == occ_pkg::ST_WAIT_P || state_r == occ_pkg::ST_WAIT_T))
    else $error("sine/cosine completion outside a wait state");

  // A start is only issued to an idle sine/cosine unit.
  a_sc_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sc_start |-> !sc_st.busy)
    else $error("sine/cosine unit started while busy");

  // Leaving the output state always presents a result.
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == occ_pkg::ST_OUT && out_free) |=> out_valid_r)
    else $error("tick finished without a result beat");

  // A tick beat always starts the camera sequence.
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == occ_pkg::CMD_TICK) |=> (state_r == occ_pkg::ST_SC_P))
    else $error("tick beat did not start the camera sequence");

endmodule
